// ===== hdl/battery_discharge_poweroff_monitor_top_defines.svh =====
// Assertion macros shared by the battery monitor RTL.
// No dependencies; expects clk and rst_n in the including module's scope.
`ifndef BATTERY_DISCHARGE_POWEROFF_MONITOR_TOP_DEFINES_SVH
`define BATTERY_DISCHARGE_POWEROFF_MONITOR_TOP_DEFINES_SVH

// same-cycle implication
`define BDPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bdpm_pkg.sv =====
// Shared types and constants for the battery discharge power-off monitor.
// No dependencies.
`timescale 1ns / 1ps

package bdpm_pkg;

  localparam int HISTORY_DEPTH_DEF = 20;

  localparam int MV_W      = 13;
  localparam int SOC_W     = 15;
  localparam int CUR_W     = 16;
  localparam int HEALTH_W  = 2;
  localparam int VWORD_W   = 16;
  localparam int SWORD_W   = 16;
  localparam int TREND_W   = 6;
  localparam int SCORE_EXT_W = 8;

  localparam int LOW_I_W    = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic [MV_W-1:0]    LOW_V_RST = 13'd3400;
  localparam logic [LOW_I_W-1:0] LOW_I_RST = 15'd1000;
  localparam logic [SOC_W-1:0]   SOC_ONE_PCT = 15'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOW_V     = 2'd0,
    CFG_LOW_I     = 2'd1,
    CFG_MODEL_SOC = 2'd2,
    CFG_OFFMODE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [HEALTH_W-1:0] {
    HEALTH_OTHER    = 2'd0,
    HEALTH_OVERHEAT = 2'd1,
    HEALTH_COLD     = 2'd2,
    HEALTH_RSVD     = 2'd3
  } health_t;

  // history store control
  typedef struct packed {
    logic we;
    logic clr_all;
  } hist_ctrl_t;

  // compare unit control
  typedef struct packed {
    logic clr;
    logic en;
  } cmp_ctrl_t;

  // ((w >> 4) * 1250) / 1000 == ((w >> 4) * 5) >> 2
  function automatic logic [MV_W-1:0] vword_to_mv(input logic [VWORD_W-1:0] w);
    logic [14:0] prod;
    prod = 15'(w[15:4]) * 15'd5;
    return prod[14:2];
  endfunction

  // model: w * 1953125 / 10000000 == (w * 25) >> 7
  // byte : hi * 100 + (lo * 100) >> 8
  function automatic logic [SOC_W-1:0] sword_to_soc(input logic [SWORD_W-1:0] w,
                                                    input logic model);
    logic [20:0] mprod;
    logic [14:0] hprod;
    logic [14:0] lprod;
    mprod = 21'(w) * 21'd25;
    hprod = 15'(w[15:8]) * 15'd100;
    lprod = 15'(w[7:0]) * 15'd100;
    if (model) begin
      return SOC_W'(mprod[20:7]);
    end
    return hprod + 15'(lprod[14:8]);
  endfunction

endpackage

// ===== hdl/bdpm_hist.sv =====
// Voltage history ring storage with per-entry valid bits.
// Depends on bdpm_pkg. Invalid entries read as zero.
`timescale 1ns / 1ps

module bdpm_hist #(
  parameter int DEPTH = bdpm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bdpm_pkg::hist_ctrl_t         ctrl,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [bdpm_pkg::MV_W-1:0]    wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [bdpm_pkg::MV_W-1:0]    rd_data
);
  import bdpm_pkg::*;

  logic [MV_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [MV_W-1:0] rd_data_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctrl.clr_all) begin
        valid_r <= '0;
      end else if (ctrl.we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr] & ~ctrl.clr_all;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== hdl/bdpm_cmp.sv =====
// Shared compare/accumulate unit for the trend score.
// Depends on bdpm_pkg. One history entry per enabled cycle.
`timescale 1ns / 1ps

module bdpm_cmp #(
  parameter int DEPTH = bdpm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdpm_pkg::cmp_ctrl_t               ctrl,
  input  logic [bdpm_pkg::MV_W-1:0]         oldest,
  input  logic [bdpm_pkg::MV_W-1:0]         entry,
  output logic signed [$clog2(DEPTH):0]     score
);
  import bdpm_pkg::*;

  localparam int SCORE_W = $clog2(DEPTH) + 1;

  logic signed [SCORE_W-1:0] acc_r;
  logic signed [SCORE_W-1:0] acc_nxt;
  logic signed [SCORE_W-1:0] step;

  // oldest above entry counts down, otherwise up
  assign step = (oldest > entry) ? -SCORE_W'(1) : SCORE_W'(1);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.en) begin
      acc_nxt = acc_r + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign score = acc_r;

endmodule

// ===== hdl/battery_discharge_poweroff_monitor_top.sv =====
// Battery discharge power-off monitor, top level with sequencer and config.
// Depends on bdpm_pkg, bdpm_hist, bdpm_cmp and the defines header.
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | tdata: sample fields, tuser: mode
//  out_    | out | tvalid/tready      | tdata: result fields
//  cfg_    | in  | we (no wait)       | addr/wdata register write
//
// A sample transaction keeps in_tready low through S_WRITE, S_RD_OLD, S_LD_OLD,
// S_WALK, S_DRAIN and S_FINAL, which also waits for a free output register:
// the single comparator walks every history entry, one per cycle, after the
// write and the read of the oldest slot. A clear transaction leaves in_tready high.
// Reset clears the history valid bits at once; no clearing pass.
// The output register lets one result wait while the next sample is worked;
// a sample finishing with the result still unread waits for out_tready.
`timescale 1ns / 1ps
`include "battery_discharge_poweroff_monitor_top_defines.svh"

module battery_discharge_poweroff_monitor_top #(
  parameter int HISTORY_DEPTH = bdpm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] vcell_word, [31:16] soc_word, [47:32] charger_current_ma,
  // [49:48] health_code, [55:50] zero
  input  logic [bdpm_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [12:0] cell_mv, [27:13] charge_hundredths, [33:28] trend_score,
  // [34] power_off, [50:35] average_current_ma, [55:51] zero
  output logic [bdpm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [bdpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bdpm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bdpm_pkg::*;

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int SCORE_W = $clog2(HISTORY_DEPTH) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WRITE  = 7'b0000010,
    S_RD_OLD = 7'b0000100,
    S_LD_OLD = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FINAL  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [MV_W-1:0]    low_v_r;
  logic [LOW_I_W-1:0] low_i_r;
  logic               model_soc_r;
  logic               offmode_r;

  // captured sample
  logic [MV_W-1:0]     mv_r;
  logic [SOC_W-1:0]    soc_r;
  logic [CUR_W-1:0]    cur_r;
  logic [HEALTH_W-1:0] health_r;
  logic [MV_W-1:0]     oldest_r;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] walk_r, walk_nxt;
  logic              pend_r;
  logic [SLOT_W-1:0] pend_idx_r;

  logic                out_valid_r;
  logic [MV_W-1:0]     o_mv_r;
  logic [SOC_W-1:0]    o_soc_r;
  logic [TREND_W-1:0]  o_trend_r;
  logic                o_off_r;
  logic [CUR_W-1:0]    o_cur_r;

  hist_ctrl_t        hctrl;
  cmp_ctrl_t         cctrl;
  logic [SLOT_W-1:0] rd_addr;
  logic [MV_W-1:0]   rd_data;
  logic signed [SCORE_W-1:0] acc;

  logic in_acc, out_free, clr_acc, smp_acc, load_out;
  logic signed [SCORE_W-1:0]     score_fin;
  logic signed [SCORE_EXT_W-1:0] score_ext;
  logic chg_weak, off;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign clr_acc   = in_acc && in_tuser;
  assign smp_acc   = in_acc && !in_tuser;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == S_FINAL) && out_free;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_v_r     <= LOW_V_RST;
      low_i_r     <= LOW_I_RST;
      model_soc_r <= 1'b0;
      offmode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOW_V:     low_v_r     <= cfg_wdata[MV_W-1:0];
        CFG_LOW_I:     low_i_r     <= cfg_wdata[LOW_I_W-1:0];
        CFG_MODEL_SOC: model_soc_r <= cfg_wdata[0];
        CFG_OFFMODE:   offmode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    walk_nxt  = walk_r;
    case (state_r)
      S_IDLE: begin
        if (clr_acc) begin
          slot_nxt = '0;
        end else if (smp_acc) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
        state_nxt = S_RD_OLD;
      end
      S_RD_OLD: state_nxt = S_LD_OLD;
      S_LD_OLD: begin
        walk_nxt  = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        walk_nxt = walk_r + SLOT_W'(1);
        if (walk_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FINAL;
      S_FINAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      walk_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      walk_r  <= walk_nxt;
      pend_r  <= (state_r == S_WALK);
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      mv_r     <= vword_to_mv(in_tdata[15:0]);
      soc_r    <= sword_to_soc(in_tdata[31:16], model_soc_r);
      cur_r    <= in_tdata[47:32];
      health_r <= in_tdata[49:48];
    end
    if (state_r == S_LD_OLD) begin
      oldest_r <= rd_data;
    end
    pend_idx_r <= walk_r;
  end

  assign hctrl.we      = (state_r == S_WRITE);
  assign hctrl.clr_all = clr_acc;
  assign rd_addr       = (state_r == S_WALK) ? walk_r : slot_r;

  // the oldest slot itself is skipped
  assign cctrl.clr = (state_r == S_LD_OLD);
  assign cctrl.en  = pend_r && (pend_idx_r != slot_r);

  bdpm_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (hctrl),
    .wr_addr (slot_r),
    .wr_data (mv_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bdpm_cmp #(.DEPTH(HISTORY_DEPTH)) u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (cctrl),
    .oldest (oldest_r),
    .entry  (rd_data),
    .score  (acc)
  );

  // decision
  assign score_fin = (oldest_r == '0) ? '0 : acc;
  assign score_ext = SCORE_EXT_W'(score_fin);
  assign chg_weak = ($signed(cur_r) < $signed({1'b0, low_i_r})) ||
                    (health_r == HEALTH_OVERHEAT) || (health_r == HEALTH_COLD);
  assign off  = !offmode_r && (soc_r < SOC_ONE_PCT) && (mv_r < low_v_r) &&
                score_fin[SCORE_W-1] && chg_weak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_mv_r    <= mv_r;
      o_soc_r   <= soc_r;
      o_trend_r <= score_ext[TREND_W-1:0];
      o_off_r   <= off;
      o_cur_r   <= off ? '1 : cur_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_cur_r, o_off_r, o_trend_r, o_soc_r, o_mv_r};

  `BDPM_ASSERT_NEXT(a_clear_slot, clr_acc, slot_r == '0 && state_r == S_IDLE,
    "clear transaction did not reset write slot")
  `BDPM_ASSERT_NEXT(a_walk_end, state_r == S_WALK && walk_r == LAST_SLOT,
    state_r == S_DRAIN, "history walk overran")
  `BDPM_ASSERT_NOW(a_off_payload, out_tvalid && out_tdata[34],
    out_tdata[50:35] == '1 && out_tdata[12:0] < low_v_r,
    "power-off result with inconsistent payload")
  `BDPM_ASSERT_NOW(a_score_bound, state_r == S_FINAL,
    acc <= $signed(SCORE_W'(HISTORY_DEPTH - 1)) &&
    acc >= -$signed(SCORE_W'(HISTORY_DEPTH - 1)),
    "trend score outside entry count")

endmodule

// ===== sim/bdpm_poweroff_scoreboard.sv =====
// Scoreboard for the battery discharge power-off monitor: mirrors the register
// writes, predicts each sample result and compares it with the out_ stream.
// Depends on bdpm_pkg.
`timescale 1ns / 1ps

module bdpm_poweroff_scoreboard #(
  parameter int DEPTH = bdpm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bdpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bdpm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [bdpm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bdpm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               pending
);
  import bdpm_pkg::*;

  typedef struct {
    logic [MV_W-1:0]            cell_mv;
    logic [SOC_W-1:0]           charge;
    logic signed [TREND_W-1:0]  trend;
    logic                       power_off;
    logic signed [CUR_W-1:0]    avg_current;
  } reading_t;

  logic [MV_W-1:0]    low_mv_lim = LOW_V_RST;
  logic [LOW_I_W-1:0] low_ma_lim = LOW_I_RST;
  logic               model_soc  = 1'b0;
  logic               offmode    = 1'b0;

  logic [MV_W-1:0] volt_ring [DEPTH];
  int              ring_ptr = 0;
  reading_t        due_readings [$];
  int              fails = 0;

  // Stores the new voltage, scores the oldest entry and decides power-off.
  function automatic reading_t forecast_poweroff(input logic [IN_TDATA_W-1:0] d);
    logic [VWORD_W-1:0]      vword;
    logic [SWORD_W-1:0]      sword;
    logic signed [CUR_W-1:0] amps;
    health_t                 health;
    int                      mv;
    int                      soc;
    int                      score;
    int                      oldest;
    logic                    chg_weak;
    logic                    off;
    reading_t                r;
    vword  = d[15:0];
    sword  = d[31:16];
    amps   = d[47:32];
    health = health_t'(d[49:48]);

    mv = ((int'(vword) >> 4) * 1250) / 1000;
    if (model_soc)
      soc = int'((longint'(sword) * 1953125) / 10000000);
    else
      soc = int'(sword[15:8]) * 100 + (int'(sword[7:0]) * 100) / 256;

    volt_ring[ring_ptr] = MV_W'(mv);
    ring_ptr = (ring_ptr + 1) % DEPTH;
    oldest = int'(volt_ring[ring_ptr]);
    score = 0;
    // an empty (zero) oldest slot means the ring is not yet full
    if (oldest != 0) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i != ring_ptr)
          score += (oldest > int'(volt_ring[i])) ? -1 : 1;
      end
    end

    chg_weak = (int'(amps) < int'(low_ma_lim)) || health == HEALTH_OVERHEAT ||
               health == HEALTH_COLD;
    off = !offmode && soc < int'(SOC_ONE_PCT) && mv < int'(low_mv_lim) &&
          score < 0 && chg_weak;

    r.cell_mv     = MV_W'(mv);
    r.charge      = SOC_W'(soc);
    r.trend       = TREND_W'(score);
    r.power_off   = off;
    r.avg_current = off ? -16'sd1 : amps;
    return r;
  endfunction

  function automatic int field_diff(input string name, input longint want,
                                    input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      low_mv_lim = LOW_V_RST;
      low_ma_lim = LOW_I_RST;
      model_soc  = 1'b0;
      offmode    = 1'b0;
      foreach (volt_ring[i]) volt_ring[i] = '0;
      ring_ptr = 0;
      due_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_LOW_V:     low_mv_lim = cfg_wdata[MV_W-1:0];
          CFG_LOW_I:     low_ma_lim = cfg_wdata[LOW_I_W-1:0];
          CFG_MODEL_SOC: model_soc  = cfg_wdata[0];
          CFG_OFFMODE:   offmode    = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        // tuser set: clear request, no result
        if (in_tuser) begin
          foreach (volt_ring[i]) volt_ring[i] = '0;
          ring_ptr = 0;
        end else begin
          due_readings.push_back(forecast_poweroff(in_tdata));
        end
      end

      if (out_tvalid && out_tready) begin
        if (due_readings.size() == 0) begin
          $error("result transaction with no expected reading: tdata %h", out_tdata);
          fails++;
        end else begin
          want = due_readings.pop_front();
          got.cell_mv     = out_tdata[12:0];
          got.charge      = out_tdata[27:13];
          got.trend       = $signed(out_tdata[33:28]);
          got.power_off   = out_tdata[34];
          got.avg_current = $signed(out_tdata[50:35]);
          fails += field_diff("cell_mv", want.cell_mv, got.cell_mv);
          fails += field_diff("charge_hundredths", want.charge, got.charge);
          fails += field_diff("trend_score", want.trend, got.trend);
          fails += field_diff("power_off", want.power_off, got.power_off);
          fails += field_diff("average_current_ma", want.avg_current, got.avg_current);
        end
      end
    end
    pending    <= due_readings.size();
    fail_count <= fails;
  end

endmodule

// ===== sim/battery_discharge_poweroff_monitor_top_test.sv =====
// Testbench top for the battery discharge power-off monitor: clock, reset,
// register settings and sample stimulus. Depends on bdpm_pkg, the monitor RTL
// and bdpm_poweroff_scoreboard, which does all result checking.
`timescale 1ns / 1ps

module battery_discharge_poweroff_monitor_top_test;
  import bdpm_pkg::*;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_CLEAR   = 1'b1;
  localparam int   SETTLE_CYCLES = HISTORY_DEPTH_DEF + 10;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  int                     fail_count;
  int                     pending;

  logic calm       = 1'b0;  // no idling on either side
  int   stall_left = 0;
  int   level      = 3000;  // falling cell level, 1.25 mV steps
  int   cur_low_ma = 1000;

  battery_discharge_poweroff_monitor_top #(.HISTORY_DEPTH(HISTORY_DEPTH_DEF)) dut (.*);

  bdpm_poweroff_scoreboard #(.DEPTH(HISTORY_DEPTH_DEF)) scoreboard (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: short random stalls, now and then a long one
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 999) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(10, 30);
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 13);
    end
  end

  task automatic send(input logic mode, input logic [15:0] vword,
                      input logic [15:0] sword, input logic [15:0] amps,
                      input health_t health);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 13)
      gap = $urandom_range(1, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'b0, health, amps, sword, vword};
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly discharge runs with random content, some noise and clears
  task automatic random_item();
    int            pick;
    logic [15:0]   vw;
    logic [15:0]   sw;
    logic [15:0]   amps;
    health_t       hc;
    pick = $urandom_range(0, 99);
    hc   = health_t'($urandom_range(0, 3));
    if (pick < 3) begin
      send(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), hc);
      level = $urandom_range(1500, 4095);
      return;
    end
    if (pick < 23) begin
      send(MODE_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), hc);
      return;
    end
    if ($urandom_range(0, 19) == 0)
      level += $urandom_range(0, 300);
    else
      level -= $urandom_range(0, 25);
    if (level < 0) level = 0;
    if (level > 4095) level = 4095;
    vw = {level[11:0], 4'($urandom)};
    if ($urandom_range(0, 49) == 0)
      vw = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 60)
      sw = 16'($urandom_range(0, 511));
    else
      sw = 16'($urandom);
    if ($urandom_range(0, 1) == 0)
      amps = 16'(cur_low_ma - 200 + int'($urandom_range(0, 400)));
    else
      amps = 16'($urandom);
    send(MODE_SAMPLE, vw, sw, amps, hc);
  endtask

  // wait for every expected result, then let a dropped-result item settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [MV_W-1:0] lv, input logic [LOW_I_W-1:0] li,
                           input logic model, input logic offm);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LOW_V;
    cfg_wdata <= CFG_DATA_W'(lv);
    @(posedge clk);
    cfg_addr  <= CFG_LOW_I;
    cfg_wdata <= CFG_DATA_W'(li);
    @(posedge clk);
    cfg_addr  <= CFG_MODEL_SOC;
    cfg_wdata <= CFG_DATA_W'(model);
    @(posedge clk);
    cfg_addr  <= CFG_OFFMODE;
    cfg_wdata <= CFG_DATA_W'(offm);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_low_ma = int'(li);
  endtask

  task automatic run_phase(input logic [MV_W-1:0] lv, input logic [LOW_I_W-1:0] li,
                           input logic model, input logic offm, input int count,
                           input logic quiet);
    drain();
    configure(lv, li, model, offm);
    calm  <= quiet;
    level = $urandom_range(1500, 4095);
    repeat (count) random_item();
  endtask

  initial begin
    logic [15:0] amps_pick [4];
    amps_pick = '{16'h7FFF, 16'd999, 16'd1000, 16'hFFFB};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: field extremes, then a steady fall that fills the ring
    send(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'h7FFF, HEALTH_RSVD);
    send(MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h7FFF, HEALTH_OTHER);
    send(MODE_SAMPLE, 16'h000F, 16'h0000, 16'h8000, HEALTH_RSVD);
    for (int i = 0; i < 20; i++)
      send(MODE_SAMPLE, 16'(((2700 - 10 * i) << 4) | (i & 15)), 16'(i * 13),
           amps_pick[i % 4], health_t'(i % 4));
    send(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, HEALTH_OTHER);
    send(MODE_SAMPLE, 16'h1234, 16'h00FF, 16'hFFFF, HEALTH_COLD);

    run_phase(13'd8191, 15'd32767, 1'b0, 1'b0, 150, 1'b0);
    run_phase(13'd0, 15'd0, 1'b1, 1'b0, 120, 1'b0);
    run_phase(13'd8191, 15'd32767, 1'b1, 1'b1, 120, 1'b0);
    run_phase(13'd4000, 15'd500, 1'b0, 1'b0, 150, 1'b1);
    run_phase(13'd8191, 15'd32767, 1'b1, 1'b0, 150, 1'b0);
    drain();

    if (fail_count == 0)
      $display("battery_discharge_poweroff_monitor_top_test: clean");
    else
      $display("battery_discharge_poweroff_monitor_top_test: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("battery_discharge_poweroff_monitor_top_test: errors");
    $finish;
  end

endmodule
